// ===== sv/bmp24_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp24_pkg: shared types and constants for the 24-bit BMP stream writer
// Field widths, header constants, geometry and job records, header byte lookup.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    localparam int CFG_W      = 13;
    localparam int CFG_MAX    = (1 << CFG_W) - 1;
    localparam int CFG_IDX_W  = 4;
    localparam int COMP_W     = 8;
    localparam int OFF_W      = 26;
    localparam int W3_W       = 15;
    localparam int ISIZE_W    = 28;
    localparam int HDR_IDX_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam logic [7:0]  MAGIC_B    = 8'h42;
    localparam logic [7:0]  MAGIC_M    = 8'h4D;
    localparam logic [31:0] HDR_BYTES  = 32'd54;
    localparam logic [31:0] DIB_SIZE   = 32'd40;
    localparam logic [7:0]  PLANES     = 8'd1;
    localparam logic [7:0]  BPP        = 8'd24;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(53);

    // cycles from a config register change until the geometry is valid
    localparam logic [1:0]  GEOM_LATENCY = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]   eff_w;
        logic [CFG_W-1:0]   eff_h;
        logic [W3_W-1:0]    w3;
        logic [1:0]         pad;
        logic [W3_W-1:0]    stride;
        logic [ISIZE_W-1:0] isize;
        logic [31:0]        total_bytes;
        logic [OFF_W-1:0]   frame_base;
    } geom_t;

    typedef struct packed {
        logic              hdr;
        logic              has_pad;
        logic [1:0]        pad;
        logic [OFF_W-1:0]  pix_off;
        logic [OFF_W-1:0]  pad_off;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } job_t;

    function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                            input geom_t g);
        logic [31:0] w32;
        logic [31:0] h32;
        logic [31:0] s32;
        logic [7:0]  b;
        w32 = 32'(g.eff_w);
        h32 = 32'(g.eff_h);
        s32 = 32'(g.isize);
        unique case (idx)
            6'd0:    b = MAGIC_B;
            6'd1:    b = MAGIC_M;
            6'd2:    b = g.total_bytes[7:0];
            6'd3:    b = g.total_bytes[15:8];
            6'd4:    b = g.total_bytes[23:16];
            6'd5:    b = g.total_bytes[31:24];
            6'd10:   b = HDR_BYTES[7:0];
            6'd14:   b = DIB_SIZE[7:0];
            6'd18:   b = w32[7:0];
            6'd19:   b = w32[15:8];
            6'd20:   b = w32[23:16];
            6'd21:   b = w32[31:24];
            6'd22:   b = h32[7:0];
            6'd23:   b = h32[15:8];
            6'd24:   b = h32[23:16];
            6'd25:   b = h32[31:24];
            6'd26:   b = PLANES;
            6'd28:   b = BPP;
            6'd34:   b = s32[7:0];
            6'd35:   b = s32[15:8];
            6'd36:   b = s32[23:16];
            6'd37:   b = s32[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/bmp24_if.sv =====
// ----------------------------------------------------------------------------
// bmp24 channel interfaces
// Pixel input, byte write output and register write channels (valid/ready).
// ----------------------------------------------------------------------------
interface bmp24_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bmp24_pkg::COMP_W-1:0]  red;
    logic [bmp24_pkg::COMP_W-1:0]  green;
    logic [bmp24_pkg::COMP_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bmp24_wr_if;
    logic                          valid;
    logic                          ready;
    logic [bmp24_pkg::OFF_W-1:0]   byte_offset;
    logic [7:0]                    byte_value;
    logic                          last_of_run;

    modport source (output valid, output byte_offset, output byte_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input byte_offset, input byte_value,
                    input last_of_run, output ready);
endinterface

interface bmp24_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmp24_pkg::CFG_IDX_W-1:0] index;
    logic [bmp24_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/bmp24_geom.sv =====
// ----------------------------------------------------------------------------
// bmp24_geom: frame geometry
// Clamps the configured size and derives stride, padding, image size and the
// offset of the last file row (top image row), over three register stages.
// ----------------------------------------------------------------------------
module bmp24_geom #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           clk,
    input  logic [bmp24_pkg::CFG_W-1:0]    cfg_width,
    input  logic [bmp24_pkg::CFG_W-1:0]    cfg_height,
    output bmp24_pkg::geom_t               geom
);

    localparam int EFF_W_MAX = (MAX_WIDTH  < bmp24_pkg::CFG_MAX) ? MAX_WIDTH  : bmp24_pkg::CFG_MAX;
    localparam int EFF_H_MAX = (MAX_HEIGHT < bmp24_pkg::CFG_MAX) ? MAX_HEIGHT : bmp24_pkg::CFG_MAX;

    logic [bmp24_pkg::CFG_W-1:0]   eff_w_next, eff_h_next;
    logic [bmp24_pkg::W3_W-1:0]    w3_next, stride_next;
    logic [1:0]                    pad_next;

    logic [bmp24_pkg::CFG_W-1:0]   eff_w_reg, eff_h_reg, hm1_reg;
    logic [bmp24_pkg::W3_W-1:0]    w3_reg, stride_reg;
    logic [1:0]                    pad_reg;
    logic [bmp24_pkg::ISIZE_W-1:0] isize_reg, rows_reg;
    logic [31:0]                   total_bytes_reg;
    logic [bmp24_pkg::OFF_W-1:0]   frame_base_reg;

    always_comb
    begin
        eff_w_next  = (32'(cfg_width)  > 32'(EFF_W_MAX)) ? bmp24_pkg::CFG_W'(EFF_W_MAX)
                                                          : cfg_width;
        eff_h_next  = (32'(cfg_height) > 32'(EFF_H_MAX)) ? bmp24_pkg::CFG_W'(EFF_H_MAX)
                                                          : cfg_height;
        w3_next     = bmp24_pkg::W3_W'(eff_w_next) + (bmp24_pkg::W3_W'(eff_w_next) << 1);
        // pad row to a multiple of four bytes
        pad_next    = 2'(3'd4 - {1'b0, w3_next[1:0]});
        stride_next = w3_next + bmp24_pkg::W3_W'(pad_next);
    end

    always_ff @(posedge clk)
    begin
        eff_w_reg       <= eff_w_next;
        eff_h_reg       <= eff_h_next;
        hm1_reg         <= eff_h_next - bmp24_pkg::CFG_W'(1);
        w3_reg          <= w3_next;
        pad_reg         <= pad_next;
        stride_reg      <= stride_next;
        isize_reg       <= bmp24_pkg::ISIZE_W'(stride_reg) * bmp24_pkg::ISIZE_W'(eff_h_reg);
        rows_reg        <= bmp24_pkg::ISIZE_W'(stride_reg) * bmp24_pkg::ISIZE_W'(hm1_reg);
        total_bytes_reg <= bmp24_pkg::HDR_BYTES + 32'(isize_reg);
        frame_base_reg  <= bmp24_pkg::OFF_W'(bmp24_pkg::HDR_BYTES + 32'(rows_reg));
    end

    always_comb
    begin
        geom.eff_w       = eff_w_reg;
        geom.eff_h       = eff_h_reg;
        geom.w3          = w3_reg;
        geom.pad         = pad_reg;
        geom.stride      = stride_reg;
        geom.isize       = isize_reg;
        geom.total_bytes = total_bytes_reg;
        geom.frame_base  = frame_base_reg;
    end

endmodule

// ===== sv/bmp24_pos.sv =====
// ----------------------------------------------------------------------------
// bmp24_pos: raster position tracker
// Keeps column, row and current row base; builds the byte job for a pixel.
// ----------------------------------------------------------------------------
module bmp24_pos #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          load,
    input  bmp24_pkg::geom_t              geom,
    input  logic [bmp24_pkg::COMP_W-1:0]  red,
    input  logic [bmp24_pkg::COMP_W-1:0]  green,
    input  logic [bmp24_pkg::COMP_W-1:0]  blue,
    output bmp24_pkg::job_t               job
);

    localparam int EFF_W_MAX = (MAX_WIDTH  < bmp24_pkg::CFG_MAX) ? MAX_WIDTH  : bmp24_pkg::CFG_MAX;
    localparam int EFF_H_MAX = (MAX_HEIGHT < bmp24_pkg::CFG_MAX) ? MAX_HEIGHT : bmp24_pkg::CFG_MAX;
    localparam int COL_W     = $clog2(EFF_W_MAX + 1);
    localparam int ROW_W     = $clog2(EFF_H_MAX + 1);
    localparam int CNT_W     = bmp24_pkg::CFG_W + 1;

    logic [COL_W-1:0]              col_reg, col_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [bmp24_pkg::OFF_W-1:0]   row_base_reg, row_base_next;

    logic                          is_hdr, row_end, frame_end;
    logic [bmp24_pkg::OFF_W-1:0]   base;
    logic [bmp24_pkg::W3_W-1:0]    col_ext, col3;
    logic [CNT_W-1:0]              col_inc, row_inc;

    always_comb
    begin
        is_hdr    = (col_reg == '0) && (row_reg == '0);
        base      = is_hdr ? geom.frame_base : row_base_reg;
        col_ext   = bmp24_pkg::W3_W'(col_reg);
        col3      = col_ext + {col_ext[bmp24_pkg::W3_W-2:0], 1'b0};
        col_inc   = CNT_W'(col_reg) + CNT_W'(1);
        row_inc   = CNT_W'(row_reg) + CNT_W'(1);
        row_end   = col_inc >= CNT_W'(geom.eff_w);
        frame_end = row_inc >= CNT_W'(geom.eff_h);

        job.hdr     = is_hdr;
        job.has_pad = row_end && (geom.pad != 2'd0);
        job.pad     = geom.pad;
        job.pix_off = base + bmp24_pkg::OFF_W'(col3);
        job.pad_off = base + bmp24_pkg::OFF_W'(geom.w3);
        job.red     = red;
        job.green   = green;
        job.blue    = blue;

        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (load)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next      = '0;
                    row_base_next = '0;
                end
                else
                begin
                    row_next      = ROW_W'(row_inc);
                    row_base_next = base - bmp24_pkg::OFF_W'(geom.stride);
                end
            end
            else
            begin
                col_next      = COL_W'(col_inc);
                row_base_next = base;
            end
        end
        else if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule

// ===== sv/bmp24_emit.sv =====
// ----------------------------------------------------------------------------
// bmp24_emit: byte sequencer
// Walks one job (header if any, three pixel bytes, row padding if any) one byte
// per cycle into the output register while wr does not stall it.
// ----------------------------------------------------------------------------
module bmp24_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bmp24_pkg::job_t   job_in,
    input  bmp24_pkg::geom_t  geom,
    output logic              free,
    bmp24_wr_if.source        wr
);

    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_PIX = 2'd1;
    localparam logic [1:0] PH_PAD = 2'd2;

    bmp24_pkg::job_t                 job_reg;
    logic                            job_valid_reg, job_valid_next;
    logic [1:0]                      phase_reg, phase_next;
    logic [bmp24_pkg::HDR_IDX_W-1:0] idx_reg, idx_next;

    logic                            out_valid_reg, out_valid_next;
    logic [bmp24_pkg::OFF_W-1:0]     out_off_reg;
    logic [7:0]                      out_val_reg;
    logic                            out_last_reg;

    logic                            fire;
    logic [bmp24_pkg::OFF_W-1:0]     cur_off;
    logic [7:0]                      cur_val;
    logic                            cur_last;

    always_comb
    begin
        cur_off  = '0;
        cur_val  = 8'd0;
        cur_last = 1'b0;
        unique case (phase_reg)
            PH_HDR:
            begin
                cur_off = bmp24_pkg::OFF_W'(idx_reg);
                cur_val = bmp24_pkg::hdr_byte(idx_reg, geom);
            end
            PH_PIX:
            begin
                cur_off  = job_reg.pix_off + bmp24_pkg::OFF_W'(idx_reg);
                cur_val  = (idx_reg[1:0] == 2'd0) ? job_reg.blue :
                           (idx_reg[1:0] == 2'd1) ? job_reg.green : job_reg.red;
                cur_last = (idx_reg[1:0] == 2'd2) && !job_reg.has_pad;
            end
            PH_PAD:
            begin
                cur_off  = job_reg.pad_off + bmp24_pkg::OFF_W'(idx_reg);
                cur_last = idx_reg[1:0] == (job_reg.pad - 2'd1);
            end
            default:
            begin
                cur_off  = '0;
            end
        endcase

        fire = job_valid_reg && (!out_valid_reg || wr.ready);
        free = !job_valid_reg || (fire && cur_last);

        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            job_valid_next = 1'b1;
            phase_next     = job_in.hdr ? PH_HDR : PH_PIX;
            idx_next       = '0;
        end
        else if (fire)
        begin
            if (cur_last)
                job_valid_next = 1'b0;
            else if (phase_reg == PH_HDR && idx_reg == bmp24_pkg::HDR_LAST)
            begin
                phase_next = PH_PIX;
                idx_next   = '0;
            end
            else if (phase_reg == PH_PIX && idx_reg[1:0] == 2'd2)
            begin
                phase_next = PH_PAD;
                idx_next   = '0;
            end
            else
                idx_next = idx_reg + bmp24_pkg::HDR_IDX_W'(1);
        end

        if (fire)
            out_valid_next = 1'b1;
        else if (wr.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job_in;
        if (fire)
        begin
            out_off_reg  <= cur_off;
            out_val_reg  <= cur_val;
            out_last_reg <= cur_last;
        end
    end

    assign wr.valid       = out_valid_reg;
    assign wr.byte_offset = out_off_reg;
    assign wr.byte_value  = out_val_reg;
    assign wr.last_of_run = out_last_reg;

endmodule

// ===== sv/bmp24_pixel_stream_writer_top.sv =====
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_writer_top: 24-bit BMP byte stream writer
// Turns raster-order RGB pixels into (file offset, byte) writes of a BMP file.
// ----------------------------------------------------------------------------
// Channels: pix takes one RGB pixel per request; wr gives one (byte_offset,
// byte_value, last_of_run) write per request; cfg writes image_width (index 0)
// or image_height (index 1). Any cfg write restarts the frame, unless the
// sequencer loads a buffered pixel in that cycle, so the next pixel is
// preceded by the 54-byte header. Throughput is set by the byte sequencer,
// which emits one byte per cycle while wr does not stall: a pixel gives 3
// bytes, 3 + pad (0..3) at the end of a row, and 54 more on the first pixel
// of a frame. A pixel is buffered in an input register while the previous
// one is still being sent, so pixels stream with no gaps. An accepted pixel
// passes through the input, job and output registers on its way to wr.
// After reset and every cfg write, pix.ready stays low while the frame
// geometry settles through its register stages. cfg.ready is always high.
// If width or height is zero, accepted pixels are dropped without output.
// When wr stalls, the output register holds its byte, the sequencer stops and
// pix.ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_writer_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    bmp24_pix_if.sink     pix,
    bmp24_wr_if.source    wr,
    bmp24_cfg_if.sink     cfg
);

    logic [bmp24_pkg::CFG_W-1:0]  width_reg, width_next;
    logic [bmp24_pkg::CFG_W-1:0]  height_reg, height_next;
    logic [1:0]                   settle_reg, settle_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [bmp24_pkg::COMP_W-1:0] pend_red_reg, pend_green_reg, pend_blue_reg;

    bmp24_pkg::geom_t             geom;
    bmp24_pkg::job_t              job;
    logic                         cfg_fire, pix_fire, dim_zero, take, load, free;

    assign cfg.ready = 1'b1;
    assign pix.ready = (settle_reg == 2'd0) && !pend_valid_reg;

    always_comb
    begin
        cfg_fire = cfg.valid && cfg.ready;
        pix_fire = pix.valid && pix.ready;
        dim_zero = (geom.eff_w == '0) || (geom.eff_h == '0);
        take     = pend_valid_reg && (free || dim_zero);
        load     = take && !dim_zero;

        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_fire && cfg.index == bmp24_pkg::REG_WIDTH)
            width_next = cfg.data;
        if (cfg_fire && cfg.index == bmp24_pkg::REG_HEIGHT)
            height_next = cfg.data;

        if (cfg_fire)
            settle_next = bmp24_pkg::GEOM_LATENCY;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;

        if (pix_fire)
            pend_valid_next = 1'b1;
        else if (take)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= '0;
            height_reg     <= '0;
            settle_reg     <= bmp24_pkg::GEOM_LATENCY;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            settle_reg     <= settle_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            pend_red_reg   <= pix.red;
            pend_green_reg <= pix.green;
            pend_blue_reg  <= pix.blue;
        end
    end

    bmp24_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .clk        (clk),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .geom       (geom)
    );

    bmp24_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_fire),
        .load  (load),
        .geom  (geom),
        .red   (pend_red_reg),
        .green (pend_green_reg),
        .blue  (pend_blue_reg),
        .job   (job)
    );

    bmp24_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .job_in (job),
        .geom   (geom),
        .free   (free),
        .wr     (wr)
    );

endmodule
